FILE: hdl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and codes for the counter/priority task picker: request and
// result beats, the stored slot record and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_PICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Width of the slot index field of a request and of next_task.
    localparam int unsigned SLOT_FIELD_W = 6;

    // Input beat.
    typedef struct packed {
        logic       req_type;
        logic [5:0] slot_index;
        logic       slot_present;
        logic       slot_runnable;
        logic [6:0] slot_priority;
        logic [7:0] slot_counter;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [5:0] next_task;
        logic [7:0] chosen_counter;
        logic       did_recompute;
        logic       none_runnable;
    } t_out;

    // One entry of the task table.
    typedef struct packed {
        logic       present;
        logic       runnable;
        logic [6:0] priority_val;
        logic [7:0] counter;
    } t_slot;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_RECOMP = 4'b0100,
        ST_FLUSH  = 4'b1000
    } t_state;

endpackage

FILE: hdl/ctp_task_mem.sv
// ----------------------------------------------------------------------------
// ctp_task_mem
// Task slot table: one synchronous RAM with a registered read port and one
// write port, plus a valid bit per entry so that unwritten slots read as zero.
// ----------------------------------------------------------------------------
module ctp_task_mem
    import ctp_pkg::*;
#(
    parameter int unsigned NUM_TASKS = 64,
    parameter int unsigned IDX_W     = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_slot            o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_slot            i_wr_data
);

    t_slot mem [NUM_TASKS];
    logic  r_valid [NUM_TASKS];
    t_slot r_rd_data;
    logic  r_rd_vbit;

    // Table storage, written in place.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Valid bits, cleared at reset and set by any write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_vbit <= r_valid[i_rd_addr];
        end
    end

    // A slot never written reads as an empty slot.
    assign o_rd_data = r_rd_vbit ? r_rd_data : '0;

endmodule

FILE: hdl/ctp_pick_ctrl.sv
// ----------------------------------------------------------------------------
// ctp_pick_ctrl
// Sequencer for loads and picks. A pick streams the table from the top slot
// down to slot 1, tracking the best runnable counter; if that best is zero
// a second pass halves and refills every present counter, writes it back
// and scans the new values in the same sweep.
// ----------------------------------------------------------------------------
module ctp_pick_ctrl
    import ctp_pkg::*;
#(
    parameter int unsigned NUM_TASKS = 64,
    parameter int unsigned IDX_W     = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_out             o_res,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_slot            i_rd_data,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_slot            o_wr_data
);

    localparam int unsigned EXT_W = IDX_W + SLOT_FIELD_W;
    localparam logic [IDX_W-1:0] TOP_SLOT = IDX_W'(NUM_TASKS - 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_p_vld;
    logic [IDX_W-1:0] r_p_addr;
    logic             r_found, n_found;
    logic [7:0]       r_best, n_best;
    logic [IDX_W-1:0] r_win, n_win;
    t_out             r_res, n_res;

    logic             in_fire;
    logic             load_ok;
    logic [EXT_W-1:0] load_idx_ext;
    logic [8:0]       refill_sum;
    logic [7:0]       refill_cnt;
    logic [7:0]       eff_cnt;
    logic             hit;
    logic             f_found;
    logic [7:0]       f_best;
    logic [IDX_W-1:0] f_win;
    logic             pass_end;
    logic [EXT_W-1:0] win_ext;
    t_out             found_res;
    t_out             empty_res;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == ST_FLUSH);
    assign o_res       = r_res;

    // Loads beyond the table are dropped.
    assign load_idx_ext = {{IDX_W{1'b0}}, i_in.slot_index};
    assign load_ok      = load_idx_ext < EXT_W'(NUM_TASKS);

    // Refill: half the counter plus the priority, saturated to eight bits.
    assign refill_sum = {2'b00, i_rd_data.counter[7:1]} + {2'b00, i_rd_data.priority_val};
    assign refill_cnt = refill_sum[8] ? 8'hFF : refill_sum[7:0];
    assign eff_cnt    = ((r_state == ST_RECOMP) && i_rd_data.present) ? refill_cnt
                                                                      : i_rd_data.counter;

    // Running maximum; strict compare keeps the higher index on ties.
    assign hit = r_p_vld && i_rd_data.present && i_rd_data.runnable
                 && (!r_found || (eff_cnt > r_best));
    assign f_found = r_found || hit;
    assign f_best  = hit ? eff_cnt : r_best;
    assign f_win   = hit ? r_p_addr : r_win;
    assign pass_end = r_p_vld && (r_p_addr == LAST_SLOT);

    // Result beats for a found winner and for an empty table.
    assign win_ext = {{SLOT_FIELD_W{1'b0}}, f_win};
    always_comb begin
        found_res                = '0;
        found_res.next_task      = win_ext[SLOT_FIELD_W-1:0];
        found_res.chosen_counter = f_best;
        found_res.did_recompute  = (r_state == ST_RECOMP);
        found_res.none_runnable  = 1'b0;
        empty_res                = '0;
        empty_res.none_runnable  = 1'b1;
    end

    // Memory ports: reads follow the scan address, writes come from loads or refill.
    assign o_rd_en   = r_issue;
    assign o_rd_addr = r_addr;
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_p_addr;
        o_wr_data = i_rd_data;
        o_wr_data.counter = eff_cnt;
        if ((r_state == ST_IDLE) && in_fire && (i_in.req_type == REQ_LOAD)) begin
            o_wr_en                = load_ok;
            o_wr_addr              = load_idx_ext[IDX_W-1:0];
            o_wr_data.present      = i_in.slot_present;
            o_wr_data.runnable     = i_in.slot_runnable;
            o_wr_data.priority_val = i_in.slot_priority;
            o_wr_data.counter      = i_in.slot_counter;
        end else if ((r_state == ST_RECOMP) && r_p_vld && i_rd_data.present) begin
            o_wr_en = 1'b1;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_issue = r_issue;
        n_found = r_found;
        n_best  = r_best;
        n_win   = r_win;
        n_res   = r_res;
        if (r_issue) begin
            if (r_addr == LAST_SLOT) begin
                n_issue = 1'b0;
            end else begin
                n_addr = r_addr - IDX_W'(1);
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in.req_type == REQ_PICK)) begin
                    n_state = ST_SCAN;
                    n_addr  = TOP_SLOT;
                    n_issue = 1'b1;
                    n_found = 1'b0;
                    n_best  = '0;
                    n_win   = '0;
                end
            end
            ST_SCAN: begin
                n_found = f_found;
                n_best  = f_best;
                n_win   = f_win;
                if (pass_end) begin
                    if (!f_found) begin
                        n_res   = empty_res;
                        n_state = ST_FLUSH;
                    end else if (f_best != 8'd0) begin
                        n_res   = found_res;
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_RECOMP;
                        n_addr  = TOP_SLOT;
                        n_issue = 1'b1;
                        n_found = 1'b0;
                        n_best  = '0;
                        n_win   = '0;
                    end
                end
            end
            ST_RECOMP: begin
                n_found = f_found;
                n_best  = f_best;
                n_win   = f_win;
                if (pass_end) begin
                    n_res   = f_found ? found_res : empty_res;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_issue = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issue <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_p_vld <= r_issue;
        end
    end

    // Scan datapath registers.
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_p_addr <= r_addr;
        r_found  <= n_found;
        r_best   <= n_best;
        r_win    <= n_win;
        r_res    <= n_res;
    end

endmodule

FILE: hdl/counter_priority_task_picker.sv
// ----------------------------------------------------------------------------
// counter_priority_task_picker
// Task table with a counter/priority scheduling decision per pick beat.
// ----------------------------------------------------------------------------
// A load beat writes one slot of the table and returns no result. A pick
// beat sweeps the table through its one read port, one slot per cycle from
// the top slot down to slot 1; when the best runnable counter is zero a
// second sweep refills every present slot and rescans the table, and the
// result then goes to the output register. Slots read as empty after reset
// without a clearing pass. The output register lets the result wait for the
// consumer while the next beat is already accepted.
// ----------------------------------------------------------------------------
module counter_priority_task_picker
    import ctp_pkg::*;
#(
    parameter int unsigned NUM_TASKS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int unsigned IDX_W = $clog2(NUM_TASKS);

    logic             res_valid;
    logic             res_ready;
    t_out             res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_slot            rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;
    logic             r_out_vld;
    t_out             r_out;

    ctp_task_mem #(
        .NUM_TASKS(NUM_TASKS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    ctp_pick_ctrl #(
        .NUM_TASKS(NUM_TASKS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A pick beat blocks further input until its result is out of the sequencer.
    a_pick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.req_type == REQ_PICK)) |=> !o_in_ready)
        else $error("input accepted while a pick is in progress");

    // A result held back by a full output register stays put.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result changed before it was taken");

    // An empty-table result carries slot 0, a zero counter and no refill.
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.none_runnable) |->
        ((o_out.next_task == 6'd0) && (o_out.chosen_counter == 8'd0)
         && !o_out.did_recompute))
        else $error("empty-table result with nonzero fields");

endmodule
